// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the ordered set table.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OUSST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OUSST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ousst_pkg.sv =====
// Package for the ordered set table: command and status codes, data width,
// the absent-entry value and the control struct sent to every cell.
// Depends on nothing.
package ousst_pkg;

    localparam int DATA_W = 32;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_REMOVE   = 3'd1;
    localparam logic [2:0] CMD_CONTAINS = 3'd2;
    localparam logic [2:0] CMD_GET_NTH  = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_DUP       = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Value returned by get nth when the position holds no entry.
    localparam logic signed [DATA_W-1:0] ABSENT_VALUE = -32'sd999;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic cmp;     // capture compare and position select
        logic append;  // write the new value at the fill position
        logic remove;  // shift down from the removed position
    } cell_ctl_t;

endpackage

// ===== rtl/core/ousst_cell.sv =====
// One storage cell of the ordered set table: holds one entry, compares it
// against the looked-up value and takes its upper neighbor's entry on remove.
// Depends on ousst_pkg.
module ousst_cell #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  ousst_pkg::cell_ctl_t ctl,
    input  ousst_pkg::data_t    cmp_value,
    input  ousst_pkg::data_t    wr_value,
    input  ousst_pkg::data_t    next_entry,
    input  logic [CNT_W-1:0]    count,
    input  logic [IDX_W-1:0]    pos_idx,
    input  logic [IDX_W-1:0]    del_idx,
    output ousst_pkg::data_t    entry,
    output logic                match,
    output ousst_pkg::data_t    rd_part
);
    import ousst_pkg::*;

    data_t entry_reg;
    data_t entry_next;
    logic  match_reg;
    logic  match_next;
    logic  sel_reg;
    logic  sel_next;
    logic  live;

    assign live = CNT_W'(INDEX) < count;

    always_comb
    begin
        match_next = match_reg;
        sel_next   = sel_reg;
        if (ctl.cmp)
        begin
            match_next = live && (entry_reg == cmp_value);
            sel_next   = (IDX_W'(INDEX) == pos_idx);
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.append && (count == CNT_W'(INDEX)))
        begin
            entry_next = wr_value;
        end
        else if (ctl.remove && (IDX_W'(INDEX) >= del_idx))
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
        sel_reg   <= sel_next;
    end

    assign entry   = entry_reg;
    assign match   = match_reg;
    assign rd_part = sel_reg ? entry_reg : '0;

endmodule

// ===== rtl/core/ousst_match_enc.sv =====
// Gathers the cell row: reduces the match flags to a hit and the matching
// position, and merges the selected entry for get nth.
// Depends on ousst_pkg.
module ousst_match_enc #(
    parameter int CAPACITY = 64,
    parameter int IDX_W    = 6
) (
    input  logic [CAPACITY-1:0] match,
    input  ousst_pkg::data_t    rd_part [CAPACITY],
    output logic                hit,
    output logic [IDX_W-1:0]    idx,
    output ousst_pkg::data_t    rd_value
);
    import ousst_pkg::*;

    // Stored values are distinct, so at most one flag is set and an OR of
    // the indexes encodes it.
    always_comb
    begin
        idx      = '0;
        rd_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match[i])
            begin
                idx = idx | IDX_W'(i);
            end
            rd_value = rd_value | rd_part[i];
        end
    end

    assign hit = |match;

endmodule

// ===== rtl/core/ordered_unique_set_table_top.sv =====
// Top level of the ordered set table: command handshake, the row of cells,
// the match encoder and the result register.
// Depends on ousst_pkg, ousst_cell, ousst_match_enc and assert_macros.svh.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+-------------------------------------------
//   cmd     | in        | cmd_valid/stall  | command, item_value, position
//   rsp     | out       | rsp_valid/stall  | found, read_value, entry_count, status
//
// For every item, in the accept cycle all cells compare their entry against
// item_value at once and register the result; once the output register is
// free, the table is updated (append at the fill position, or every cell
// above the removed entry takes its neighbor's value) and the result loads.
// A new item is accepted while the previous result still waits in the output
// register; the update cycle holds until that register is free.
// Reset clears the count and the handshake state; cell contents are left
// as they are, since nothing past the count is ever read.
`include "assert_macros.svh"

module ordered_unique_set_table_top #(
    parameter int CAPACITY = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  logic [2:0]               command,
    input  logic signed [31:0]       item_value,
    input  logic [5:0]               position,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic                     found,
    output logic signed [31:0]       read_value,
    output logic [6:0]               entry_count,
    output logic [1:0]               status
);
    import ousst_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Width that holds both a position and a count for comparison.
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    // Control state.
    logic             busy_reg;
    logic             busy_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Captured item.
    logic [2:0]       cmd_reg;
    data_t            value_reg;
    logic             pos_ok_reg;

    // Result register.
    logic             found_reg;
    logic             found_next;
    data_t            rd_reg;
    data_t            rd_next;
    logic [6:0]       cnt_out_reg;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;

    logic             accept;
    logic             fire;
    logic             full;
    logic [CMP_W-1:0] pos_wide;
    logic [IDX_W-1:0] pos_idx;

    cell_ctl_t        ctl;
    data_t            chain [CAPACITY+1];
    data_t            rd_parts [CAPACITY];
    logic [CAPACITY-1:0] match_w;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    data_t            rd_sel;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = busy_reg;
    // The update waits only while an older result is still held.
    assign fire      = busy_reg && !(rsp_valid_reg && rsp_stall);
    assign full      = (count_reg == CNT_W'(CAPACITY));

    assign pos_wide  = CMP_W'(position);
    assign pos_idx   = pos_wide[IDX_W-1:0];

    assign ctl.cmp    = accept;
    assign ctl.append = fire && (cmd_reg == CMD_ADD) && !hit && !full;
    assign ctl.remove = fire && (cmd_reg == CMD_REMOVE) && hit;

    // Above the top cell there is nothing to shift in.
    assign chain[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ousst_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .cmp_value  (item_value),
            .wr_value   (value_reg),
            .next_entry (chain[i+1]),
            .count      (count_reg),
            .pos_idx    (pos_idx),
            .del_idx    (hit_idx),
            .entry      (chain[i]),
            .match      (match_w[i]),
            .rd_part    (rd_parts[i])
        );
    end

    ousst_match_enc #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_enc (
        .match    (match_w),
        .rd_part  (rd_parts),
        .hit      (hit),
        .idx      (hit_idx),
        .rd_value (rd_sel)
    );

    // Outcome of the command in its update cycle.
    always_comb
    begin
        count_next  = count_reg;
        found_next  = 1'b0;
        rd_next     = '0;
        status_next = ST_OK;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                if (hit)
                begin
                    status_next = ST_DUP;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (hit)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            CMD_CONTAINS:
            begin
                found_next = hit;
                if (!hit)
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            CMD_GET_NTH:
            begin
                if (pos_ok_reg)
                begin
                    found_next = 1'b1;
                    rd_next    = rd_sel;
                end
                else
                begin
                    rd_next     = ABSENT_VALUE;
                    status_next = ST_NOT_FOUND;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                // Unused commands leave the table alone.
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (fire)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            value_reg  <= item_value;
            // The count cannot change between accept and update.
            pos_ok_reg <= pos_wide < CMP_W'(count_reg);
        end
        if (fire)
        begin
            found_reg   <= found_next;
            rd_reg      <= rd_next;
            cnt_out_reg <= 7'(count_next);
            status_reg  <= status_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_reg;
    assign read_value  = rd_reg;
    assign entry_count = cnt_out_reg;
    assign status      = status_reg;

    `OUSST_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY),
        "entry count exceeds capacity")
    `OUSST_ASSERT_NOW(a_unique_match, busy_reg, $onehot0(match_w),
        "more than one cell matches the looked-up value")
    `OUSST_ASSERT_NEXT(a_fire_gives_rsp, fire, rsp_valid,
        "update cycle did not produce a result")
    `OUSST_ASSERT_NEXT(a_count_only_on_fire, !fire, $stable(count_reg),
        "entry count changed outside an update cycle")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for ordered_unique_set_table_top, the insertion-ordered set.
// Depends on ousst_pkg for the command codes, the status codes and the data type.
// A directed table runs first, then random fill and churn phases, checked by hand values or a shadow set.
module tb;

    import ousst_pkg::*;

    localparam int CAPACITY      = 64;
    localparam int RANDOM_ITEMS  = 1625;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 10;
    localparam int STALL_LIMIT   = 1000;
    localparam int IDLE_PERCENT  = 19;

    // Command codes that the block does not decode. They must leave the table alone.
    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

    localparam data_t VAL_MIN = 32'sh8000_0000;
    localparam data_t VAL_MAX = 32'sh7FFF_FFFF;

    // One result item, with the fields in the order of the output ports.
    typedef struct packed {
        logic       found;
        data_t      read_value;
        logic [6:0] entry_count;
        logic [1:0] status;
    } set_result_t;

    // One row of the directed table. When typed is set, the result is written
    // out by hand. Otherwise the shadow set works it out.
    typedef struct packed {
        logic [2:0]  cmd;
        data_t       val;
        logic [5:0]  pos;
        logic        typed;
        set_result_t want;
    } dir_row_t;

    localparam int DIRECTED_ROWS = 25;

    // The table starts empty. It then fills with the extreme values and with a
    // real entry that equals the absent marker. After that it probes hits,
    // misses, the spare commands and clear.
    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_GET_NTH,   32'sd0,     6'd0,  1'b1, '{1'b0, ABSENT_VALUE, 7'd0, ST_NOT_FOUND}},
        '{CMD_CONTAINS,  32'sd0,     6'd0,  1'b1, '{1'b0, 32'sd0,       7'd0, ST_NOT_FOUND}},
        '{CMD_REMOVE,    32'sd5,     6'd0,  1'b1, '{1'b0, 32'sd0,       7'd0, ST_NOT_FOUND}},
        '{CMD_ADD,       VAL_MIN,    6'd0,  1'b1, '{1'b0, 32'sd0,       7'd1, ST_OK}},
        '{CMD_ADD,       VAL_MAX,    6'd63, 1'b1, '{1'b0, 32'sd0,       7'd2, ST_OK}},
        '{CMD_ADD,       -32'sd999,  6'd0,  1'b1, '{1'b0, 32'sd0,       7'd3, ST_OK}},
        '{CMD_ADD,       VAL_MIN,    6'd0,  1'b1, '{1'b0, 32'sd0,       7'd3, ST_DUP}},
        '{CMD_ADD,       32'sd0,     6'd0,  1'b1, '{1'b0, 32'sd0,       7'd4, ST_OK}},
        '{CMD_ADD,       -32'sd1,    6'd0,  1'b1, '{1'b0, 32'sd0,       7'd5, ST_OK}},
        '{CMD_CONTAINS,  VAL_MAX,    6'd0,  1'b1, '{1'b1, 32'sd0,       7'd5, ST_OK}},
        '{CMD_GET_NTH,   32'sd0,     6'd0,  1'b1, '{1'b1, VAL_MIN,      7'd5, ST_OK}},
        '{CMD_GET_NTH,   32'sd0,     6'd2,  1'b1, '{1'b1, -32'sd999,    7'd5, ST_OK}},
        '{CMD_GET_NTH,   32'sd0,     6'd5,  1'b1, '{1'b0, ABSENT_VALUE, 7'd5, ST_NOT_FOUND}},
        '{CMD_GET_NTH,   -32'sd1,    6'd63, 1'b1, '{1'b0, ABSENT_VALUE, 7'd5, ST_NOT_FOUND}},
        '{CMD_REMOVE,    VAL_MAX,    6'd0,  1'b1, '{1'b0, 32'sd0,       7'd4, ST_OK}},
        '{CMD_GET_NTH,   32'sd0,     6'd1,  1'b0, '0},
        '{CMD_GET_NTH,   32'sd0,     6'd3,  1'b0, '0},
        '{CMD_REMOVE,    VAL_MIN,    6'd0,  1'b0, '0},
        '{CMD_CONTAINS,  32'sd12345, 6'd0,  1'b1, '{1'b0, 32'sd0,       7'd3, ST_NOT_FOUND}},
        '{CMD_SPARE_LO,  -32'sd1,    6'd63, 1'b1, '{1'b0, 32'sd0,       7'd3, ST_OK}},
        '{CMD_SPARE_HI,  VAL_MAX,    6'd0,  1'b1, '{1'b0, 32'sd0,       7'd3, ST_OK}},
        '{CMD_SPARE_MID, 32'sd0,     6'd1,  1'b0, '0},
        '{CMD_CLEAR,     32'sd0,     6'd0,  1'b1, '{1'b0, 32'sd0,       7'd0, ST_OK}},
        '{CMD_GET_NTH,   32'sd0,     6'd0,  1'b1, '{1'b0, ABSENT_VALUE, 7'd0, ST_NOT_FOUND}},
        '{CMD_REMOVE,    32'sd0,     6'd0,  1'b1, '{1'b0, 32'sd0,       7'd0, ST_NOT_FOUND}}
    };

    // These values come up often, so that duplicates and hits happen on purpose.
    data_t corner_values [8] = '{VAL_MIN, VAL_MAX, 32'sd0, -32'sd1, -32'sd999,
                                 32'sd1, 32'sd2, -32'sd2};

    logic             clk;
    logic             rst_n;
    logic             cmd_valid;
    logic             cmd_stall;
    logic [2:0]       command;
    logic signed [31:0] item_value;
    logic [5:0]       position;
    logic             rsp_valid;
    logic             rsp_stall;
    logic             found;
    logic signed [31:0] read_value;
    logic [6:0]       entry_count;
    logic [1:0]       status;

    // This is the shadow copy of the set. It is updated when each item is accepted.
    data_t       shadow_entries [CAPACITY];
    int          shadow_count;
    int          peak_count;

    set_result_t answers_owed [$];

    int          items_accepted;
    int          results_checked;
    int          failures;
    int          status_tally [4];
    int          idle_cycles;

    // These flags pass between the sending and the receiving processes.
    bit          quiet;
    bit          hold_request;

    ordered_unique_set_table_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .command    (command),
        .item_value (item_value),
        .position   (position),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .found      (found),
        .read_value (read_value),
        .entry_count(entry_count),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Reset is asserted once, from time zero.
    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Applies one command to the shadow set and returns the result that the
    // block owes for it. The first match wins. A remove closes the gap, so the
    // order of the entries is kept. A duplicate is checked before a full table.
    function automatic set_result_t shadow_set_apply(logic [2:0] cmd, data_t val,
                                                     logic [5:0] pos);
        set_result_t res;
        int          hit;
        int          i;
        res        = '0;
        res.status = ST_OK;
        hit        = -1;
        for (i = 0; i < shadow_count; i++)
        begin
            if (hit < 0 && shadow_entries[i] == val)
                hit = i;
        end
        case (cmd)
            CMD_ADD:
            begin
                if (hit >= 0)
                    res.status = ST_DUP;
                else if (shadow_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    shadow_entries[shadow_count] = val;
                    shadow_count++;
                end
            end
            CMD_REMOVE:
            begin
                if (hit >= 0)
                begin
                    for (i = hit; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_count--;
                end
                else
                    res.status = ST_NOT_FOUND;
            end
            CMD_CONTAINS:
            begin
                if (hit >= 0)
                    res.found = 1'b1;
                else
                    res.status = ST_NOT_FOUND;
            end
            CMD_GET_NTH:
            begin
                if (int'(pos) < shadow_count)
                begin
                    res.found      = 1'b1;
                    res.read_value = shadow_entries[pos];
                end
                else
                begin
                    res.read_value = ABSENT_VALUE;
                    res.status     = ST_NOT_FOUND;
                end
            end
            CMD_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        res.entry_count = 7'(shadow_count);
        return res;
    endfunction

    // Picks a value for a command. It is often one already stored or one of
    // the corner values, and otherwise any 32-bit pattern.
    function automatic data_t pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40 && shadow_count > 0)
            return shadow_entries[$urandom_range(0, shadow_count - 1)];
        else if (roll < 60)
            return corner_values[$urandom_range(0, 7)];
        else
            return data_t'($urandom);
    endfunction

    // Offers one item and holds it until the block takes it. Idle cycles
    // come first at random. The valid is never lowered and raised in the same
    // step. The shadow set is updated at the edge where the item is accepted.
    task automatic send_item(logic [2:0] cmd, data_t val, logic [5:0] pos,
                             logic typed, set_result_t want);
        set_result_t predicted;
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        command    <= cmd;
        item_value <= val;
        position   <= pos;
        cmd_valid  <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predicted = shadow_set_apply(cmd, val, pos);
        answers_owed.push_back(typed ? want : predicted);
        items_accepted++;
    endtask

    // The sending side runs the directed table, then the random phases, then the drain.
    initial
    begin : command_side
        int          phase;
        int          phase_len;
        int          n;
        int          roll;
        bit          fill_phase;
        logic [2:0]  cmd;
        data_t       val;
        logic [5:0]  pos;
        cmd_valid  = 1'b0;
        command    = CMD_ADD;
        item_value = '0;
        position   = '0;
        while (rst_n !== 1'b1)
            @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].val, directed_rows[i].pos,
                      directed_rows[i].typed, directed_rows[i].want);

        // Most phases are a mix of commands on a set that slowly grows. Fill
        // phases push the set to capacity. Once it is full they take the mix,
        // whose adds give full drops, and duplicates arrive at a full set too.
        // The first phase runs with no idling on either side. The second opens
        // with a long hold on the result side while items keep coming. The
        // third waits until every result owed has come in before it starts.
        phase = 0;
        while (items_accepted < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            fill_phase = (phase == 0) || ($urandom_range(0, 2) == 0);
            phase_len  = fill_phase ? 100 : $urandom_range(80, 160);
            quiet      = (phase == 0);
            if (phase == 1)
                hold_request = 1'b1;
            if (phase == 2)
            begin
                cmd_valid <= 1'b0;
                do
                    @(posedge clk);
                while (answers_owed.size() != 0);
            end
            for (n = 0; n < phase_len && items_accepted < DIRECTED_ROWS + RANDOM_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                val  = pick_value();
                if (fill_phase && shadow_count < CAPACITY && roll < 85)
                begin
                    cmd = CMD_ADD;
                    val = data_t'($urandom);
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 34)
                        cmd = CMD_ADD;
                    else if (roll < 54)
                        cmd = CMD_REMOVE;
                    else if (roll < 69)
                        cmd = CMD_CONTAINS;
                    else if (roll < 92)
                        cmd = CMD_GET_NTH;
                    else if (roll < 94)
                        cmd = CMD_CLEAR;
                    else
                        cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                end
                // Most positions fall inside the set. Some point just past the
                // last entry, and the rest are anywhere in the field.
                roll = $urandom_range(0, 99);
                if (roll < 60 && shadow_count > 0)
                    pos = 6'($urandom_range(0, shadow_count - 1));
                else if (roll < 75 && shadow_count < CAPACITY)
                    pos = 6'(shadow_count);
                else
                    pos = 6'($urandom_range(0, 63));
                send_item(cmd, val, pos, 1'b0, '0);
            end
            phase++;
        end
        quiet = 1'b0;
        cmd_valid <= 1'b0;

        // Wait until every result has come, then drain for any stray one.
        while (answers_owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items (%0d directed) in %0d phases, %0d results checked.",
                 items_accepted, DIRECTED_ROWS, phase, results_checked);
        $display("Peak size %0d of %0d; %0d ok, %0d full drops, %0d duplicates, %0d misses.",
                 peak_count, CAPACITY, status_tally[ST_OK], status_tally[ST_FULL],
                 status_tally[ST_DUP], status_tally[ST_NOT_FOUND]);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // The receiving side stalls at random, except in quiet phases. When a
    // hold is requested, it keeps the stall high for a long stretch so that
    // the block backs up and stalls its input.
    initial
    begin : result_side
        int held;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_stall <= 1'b1;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            else
                rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Each accepted result is compared field by field with the oldest result owed.
    always @(posedge clk)
    begin : result_check
        set_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answers_owed.size() == 0)
            begin
                $error("result arrived with no item outstanding");
                failures++;
            end
            else
            begin
                want = answers_owed.pop_front();
                results_checked++;
                status_tally[status]++;
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    failures++;
                end
                if (read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d", want.read_value, read_value);
                    failures++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
                    failures++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    failures++;
                end
            end
        end
    end

    // The run is stopped if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
